// ===== hw/rtl/pge_pkg.sv =====
// Shared types, constants and lookup functions of the pheromone grid engine.
// No dependencies; every other file but pge_ram imports this package.
package pge_pkg;

   localparam int MAX_COLS    = 128;
   localparam int MAX_ROWS    = 128;
   localparam int NUM_LAYERS  = 3;
   localparam int LEVEL_BITS  = 16;
   localparam int COL_BITS    = $clog2(MAX_COLS);
   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int LAYER_BITS  = 2;
   localparam int ADDR_BITS   = LAYER_BITS + ROW_BITS + COL_BITS;
   localparam int STORE_DEPTH = NUM_LAYERS * MAX_ROWS * MAX_COLS;

   // operation codes
   localparam logic [2:0] KIND_DEPOSIT  = 3'd0;
   localparam logic [2:0] KIND_SAMPLE   = 3'd1;
   localparam logic [2:0] KIND_STEER    = 3'd2;
   localparam logic [2:0] KIND_EVAPORATE = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;

   localparam logic [1:0] LAYER_DANGER = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_GRID_COLS   = 3'd0;
   localparam logic [2:0] CSR_GRID_ROWS   = 3'd1;
   localparam logic [2:0] CSR_CELL_SHIFT  = 3'd2;
   localparam logic [2:0] CSR_MAX_LEVEL   = 3'd3;
   localparam logic [2:0] CSR_THRESHOLD   = 3'd4;
   localparam logic [2:0] CSR_TRAIL_KEEP  = 3'd5;
   localparam logic [2:0] CSR_DANGER_KEEP = 3'd6;

   localparam logic [14:0] BEHIND_FACTOR = 15'd19661;  // 0.3 in Q0.16
   localparam logic [16:0] QUARTER_TURN  = 17'h04000;
   localparam logic [2:0]  NBR_LAST      = 3'd7;

   typedef struct packed {
      logic load;        // capture the accepted item
      logic dep_write;   // write the saturated deposit sum
      logic cap_level;   // capture the sampled level
      logic steer_step;  // read the next neighbor
      logic sweep_start; // rewind the sweep address
      logic sweep_step;  // visit the next stored cell
      logic sweep_evap;  // sweep scales instead of clearing
      logic out_load;    // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       on_grid;
      logic       steer_last;
      logic       sweep_last;
   } status_type;

   function automatic logic [15:0] nb_angle(input logic [2:0] idx);
      logic [15:0] a;
      case (idx)
         3'd0:    a = 16'hA000;
         3'd1:    a = 16'hC000;
         3'd2:    a = 16'hE000;
         3'd3:    a = 16'h8000;
         3'd4:    a = 16'h0000;
         3'd5:    a = 16'h6000;
         3'd6:    a = 16'h4000;
         default: a = 16'h2000;
      endcase
      return a;
   endfunction

   function automatic logic signed [1:0] nb_dx(input logic [2:0] idx);
      logic signed [1:0] d;
      case (idx)
         3'd0, 3'd3, 3'd5: d = -2'sd1;
         3'd1, 3'd6:       d = 2'sd0;
         default:          d = 2'sd1;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] nb_dy(input logic [2:0] idx);
      logic signed [1:0] d;
      case (idx)
         3'd0, 3'd1, 3'd2: d = -2'sd1;
         3'd3, 3'd4:       d = 2'sd0;
         default:          d = 2'sd1;
      endcase
      return d;
   endfunction

endpackage

// ===== hw/rtl/pge_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pge_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/pge_datapath.sv =====
// Datapath: configuration registers, item registers, cell mapping, steer pipeline,
// sweep address, level store and output register. Depends on pge_pkg, pge_ram.
module pge_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_addr,
   input  logic [15:0]         csr_wdata,
   input  logic [2:0]          in_kind,
   input  logic [1:0]          in_layer,
   input  logic [15:0]         in_pos_x,
   input  logic [15:0]         in_pos_y,
   input  logic [15:0]         in_amount,
   input  logic [15:0]         in_heading,
   input  pge_pkg::cmd_type    cmd,
   output pge_pkg::status_type status,
   output logic [15:0]         out_level,
   output logic                out_found,
   output logic [15:0]         out_direction,
   output logic [2:0]          out_kind
);
   import pge_pkg::*;

   logic [7:0]  grid_cols_ff, grid_rows_ff;
   logic [3:0]  cell_shift_ff;
   logic [15:0] max_level_ff, threshold_ff, trail_keep_ff, danger_keep_ff;

   logic [2:0]  kind_ff;
   logic [1:0]  layer_ff;
   logic [15:0] pos_x_ff, pos_y_ff, amount_ff, heading_ff;

   logic [7:0]  cols_eff, rows_eff;
   logic [14:0] x_sh, y_sh;
   logic        on_grid;
   logic [COL_BITS-1:0] gx;
   logic [ROW_BITS-1:0] gy;
   logic [ADDR_BITS-1:0] cell_addr;

   logic [2:0]  nbr_ff;
   logic signed [COL_BITS+1:0] nx;
   logic signed [ROW_BITS+1:0] ny;
   logic        nb_in;
   logic [ADDR_BITS-1:0] nb_addr;

   logic        st_ok_ff;
   logic [2:0]  st_idx_ff;
   logic        wv_ff;
   logic [31:0] w_ff;
   logic [2:0]  w_idx_ff;
   logic [15:0] ang;
   logic [15:0] dang;
   logic [16:0] adang;
   logic [31:0] weight;
   logic [31:0] best_w_ff;
   logic        best_found_ff;
   logic [15:0] best_angle_ff;
   logic [15:0] level_ff;

   logic [ADDR_BITS-1:0] sweep_ff;
   logic [ADDR_BITS-1:0] ev_addr_ff;
   logic        ev_v_ff;
   logic [15:0] keep_sel;
   logic [31:0] scaled;
   logic [16:0] dep_sum;
   logic [LEVEL_BITS-1:0] dep_sat;

   logic        ram_we;
   logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
   logic [LEVEL_BITS-1:0] ram_wdata, ram_rdata;

   logic [15:0] rsp_level_ff, rsp_direction_ff;
   logic        rsp_found_ff;
   logic [2:0]  rsp_kind_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff   <= 8'd128;
         grid_rows_ff   <= 8'd128;
         cell_shift_ff  <= 4'd4;
         max_level_ff   <= 16'hFFFF;
         threshold_ff   <= 16'd1;
         trail_keep_ff  <= 16'hFFFF;
         danger_keep_ff <= 16'hFFFF;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_GRID_COLS:   grid_cols_ff   <= csr_wdata[7:0];
            CSR_GRID_ROWS:   grid_rows_ff   <= csr_wdata[7:0];
            CSR_CELL_SHIFT:  cell_shift_ff  <= csr_wdata[3:0];
            CSR_MAX_LEVEL:   max_level_ff   <= csr_wdata;
            CSR_THRESHOLD:   threshold_ff   <= csr_wdata;
            CSR_TRAIL_KEEP:  trail_keep_ff  <= csr_wdata;
            CSR_DANGER_KEEP: danger_keep_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= in_kind;
         layer_ff   <= in_layer;
         pos_x_ff   <= in_pos_x;
         pos_y_ff   <= in_pos_y;
         amount_ff  <= in_amount;
         heading_ff <= in_heading;
      end
   end

   // cell mapping
   assign cols_eff = ({8'd0, grid_cols_ff} > 16'(MAX_COLS)) ? 8'(MAX_COLS) : grid_cols_ff;
   assign rows_eff = ({8'd0, grid_rows_ff} > 16'(MAX_ROWS)) ? 8'(MAX_ROWS) : grid_rows_ff;
   assign x_sh = pos_x_ff[14:0] >> cell_shift_ff;
   assign y_sh = pos_y_ff[14:0] >> cell_shift_ff;
   assign on_grid = !pos_x_ff[15] && !pos_y_ff[15] && (32'(layer_ff) < 32'(NUM_LAYERS))
                    && (16'(x_sh) < 16'(cols_eff)) && (16'(y_sh) < 16'(rows_eff));
   assign gx = x_sh[COL_BITS-1:0];
   assign gy = y_sh[ROW_BITS-1:0];
   assign cell_addr = {layer_ff, gy, gx};

   // neighbor address
   assign nx = signed'({2'b00, gx}) + (COL_BITS+2)'(nb_dx(nbr_ff));
   assign ny = signed'({2'b00, gy}) + (ROW_BITS+2)'(nb_dy(nbr_ff));
   assign nb_in = !nx[COL_BITS+1] && !ny[ROW_BITS+1]
                  && (16'(nx[COL_BITS:0]) < 16'(cols_eff))
                  && (16'(ny[ROW_BITS:0]) < 16'(rows_eff));
   assign nb_addr = {layer_ff, ny[ROW_BITS-1:0], nx[COL_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         nbr_ff <= 3'd0;
      end else if (cmd.steer_step) begin
         nbr_ff <= nbr_ff + 3'd1;
      end
   end

   // steer weighting: read, weigh, compare
   assign ang   = nb_angle(st_idx_ff);
   assign dang  = ang - heading_ff;
   assign adang = dang[15] ? (17'h10000 - {1'b0, dang}) : {1'b0, dang};
   assign weight = (adang > QUARTER_TURN) ? (32'(ram_rdata) * 32'(BEHIND_FACTOR))
                                          : {ram_rdata, 16'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ok_ff <= 1'b0;
         wv_ff    <= 1'b0;
      end else begin
         st_ok_ff <= cmd.steer_step && nb_in;
         wv_ff    <= st_ok_ff && (ram_rdata >= threshold_ff);
      end
      st_idx_ff <= nbr_ff;
      w_ff      <= weight;
      w_idx_ff  <= st_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         best_w_ff     <= 32'd0;
         best_found_ff <= 1'b0;
         best_angle_ff <= 16'd0;
         level_ff      <= 16'd0;
      end else begin
         if (wv_ff && (w_ff > best_w_ff)) begin
            best_w_ff     <= w_ff;
            best_found_ff <= 1'b1;
            best_angle_ff <= nb_angle(w_idx_ff);
         end
         if (cmd.cap_level) begin
            level_ff <= ram_rdata;
         end
      end
   end

   // sweep over the whole store
   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_start) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= status.sweep_last ? '0 : sweep_ff + ADDR_BITS'(1);
      end
      if (reset) begin
         ev_v_ff <= 1'b0;
      end else begin
         ev_v_ff <= cmd.sweep_step && cmd.sweep_evap;
      end
      ev_addr_ff <= sweep_ff;
   end

   assign keep_sel = (ev_addr_ff[ADDR_BITS-1 -: LAYER_BITS] == LAYER_DANGER)
                     ? danger_keep_ff : trail_keep_ff;
   assign scaled = 32'(ram_rdata) * 32'(keep_sel);

   assign dep_sum = 17'(ram_rdata) + 17'(amount_ff);
   assign dep_sat = (dep_sum > 17'(max_level_ff)) ? max_level_ff : dep_sum[15:0];

   // store ports
   assign ram_we    = (cmd.sweep_step && !cmd.sweep_evap) || ev_v_ff || cmd.dep_write;
   assign ram_waddr = ev_v_ff ? ev_addr_ff : (cmd.dep_write ? cell_addr : sweep_ff);
   assign ram_wdata = ev_v_ff ? scaled[31:16] : (cmd.dep_write ? dep_sat : '0);
   assign ram_raddr = cmd.steer_step ? nb_addr : (cmd.sweep_step ? sweep_ff : cell_addr);

   pge_ram #(
      .WIDTH(LEVEL_BITS),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_level_ff     <= level_ff;
         rsp_found_ff     <= best_found_ff;
         rsp_direction_ff <= best_angle_ff;
         rsp_kind_ff      <= kind_ff;
      end
   end

   assign out_level     = rsp_level_ff;
   assign out_found     = rsp_found_ff;
   assign out_direction = rsp_direction_ff;
   assign out_kind      = rsp_kind_ff;

   assign status.kind       = kind_ff;
   assign status.on_grid    = on_grid;
   assign status.steer_last = (nbr_ff == NBR_LAST);
   assign status.sweep_last = (sweep_ff == ADDR_BITS'(STORE_DEPTH - 1));

endmodule

// ===== hw/rtl/pge_ctrl.sv =====
// Controller state machine: sequences each operation and owns the result valid flag.
// Depends on pge_pkg.
module pge_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  pge_pkg::status_type status,
   output pge_pkg::cmd_type    cmd
);
   import pge_pkg::*;

   localparam logic [3:0] ST_CLR    = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DISP   = 4'd2;
   localparam logic [3:0] ST_WAIT   = 4'd3;
   localparam logic [3:0] ST_STEER  = 4'd4;
   localparam logic [3:0] ST_DRAIN1 = 4'd5;
   localparam logic [3:0] ST_DRAIN2 = 4'd6;
   localparam logic [3:0] ST_SWEEP  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLR: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (status.kind)
               KIND_DEPOSIT, KIND_SAMPLE:
                  state_in = status.on_grid ? ST_WAIT : ST_DONE;
               KIND_STEER:
                  state_in = status.on_grid ? ST_STEER : ST_DONE;
               KIND_EVAPORATE, KIND_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  state_in = ST_SWEEP;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_WAIT: begin
            cmd.dep_write = (status.kind == KIND_DEPOSIT);
            cmd.cap_level = (status.kind == KIND_SAMPLE);
            state_in = ST_DONE;
         end
         ST_STEER: begin
            cmd.steer_step = 1'b1;
            if (status.steer_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.sweep_evap = (status.kind == KIND_EVAPORATE);
            if (status.sweep_last) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> !req_tready)
      else $error("item accepted during the clearing pass");

   a_accept_dispatches: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_DISP))
      else $error("accepted item not dispatched");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> valid_ff)
      else $error("result loaded without valid");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten before it was taken");

   a_single_store_op: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.dep_write, cmd.steer_step, cmd.sweep_step}) <= 1)
      else $error("store port claimed twice");

endmodule

// ===== hw/rtl/pheromone_grid_engine.sv =====
// Top level of the pheromone grid engine: stream ports, configuration port, and the
// controller and datapath. Depends on pge_pkg, pge_ctrl, pge_datapath, pge_ram.
//
// The engine keeps three pheromone layers (food, home, danger) of 128 x 128 cells,
// 16-bit levels, in one single-port-read, single-port-write memory of 49152 words.
// After reset it runs a clearing pass over the whole store, during which req_tready
// stays low; configuration writes are taken throughout. One item is worked at a time,
// and the next item is accepted as soon as the previous result sits in the output
// register. Steer makes eight neighbor reads through the one read port plus a two-stage
// weigh and compare; evaporate and clear walk the memory one cell per cycle. Steering
// is bound by this one read port, which sets the sustained rate.
module pheromone_grid_engine (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_x[15:0], pos_y[31:16], amount[47:32], heading[63:48]
   input  logic [4:0]  req_tuser,   // kind[2:0], layer[4:3]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // level[15:0], found[16], direction[32:17], zero[39:33]
   output logic [2:0]  rsp_tuser,   // done_kind[2:0]
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import pge_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [15:0] out_level, out_direction;
   logic        out_found;
   logic [2:0]  out_kind;

   pge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   pge_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .in_kind      (req_tuser[2:0]),
      .in_layer     (req_tuser[4:3]),
      .in_pos_x     (req_tdata[15:0]),
      .in_pos_y     (req_tdata[31:16]),
      .in_amount    (req_tdata[47:32]),
      .in_heading   (req_tdata[63:48]),
      .cmd          (cmd),
      .status       (status),
      .out_level    (out_level),
      .out_found    (out_found),
      .out_direction(out_direction),
      .out_kind     (out_kind)
   );

   // pack the result; unused top bits read zero
   assign rsp_tdata = {7'd0, out_direction, out_found, out_level};
   assign rsp_tuser = out_kind;

endmodule

// ===== tb/pge_checker.sv =====
// Scoreboard for the pheromone grid engine: watches the item, result and register ports,
// keeps its own copy of the three pheromone layers and compares every result.
// Depends on pge_pkg for sizes, operation codes and register indexes.
module pge_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [4:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import pge_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LAYER_CELLS = MAX_COLS * MAX_ROWS;
   localparam int NBR_DX[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
   localparam int NBR_DY[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
   localparam logic [15:0] NBR_DIR[8] = '{16'hA000, 16'hC000, 16'hE000, 16'h8000,
                                          16'h0000, 16'h6000, 16'h4000, 16'h2000};

   typedef struct {
      logic [15:0] level;
      logic        found;
      logic [15:0] direction;
      logic [2:0]  kind;
   } outcome_type;

   logic [15:0] cell_level [STORE_DEPTH];
   logic [7:0]  cols_reg, rows_reg;
   logic [3:0]  shift_reg;
   logic [15:0] ceiling_reg, thresh_reg, trail_reg, danger_reg;
   outcome_type outcome_q [$];

   function automatic int cols_used();
      return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
   endfunction

   function automatic int rows_used();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
   endfunction

   function automatic int cell_addr(input int ly, input int gx, input int gy);
      return ly * LAYER_CELLS + gy * MAX_COLS + gx;
   endfunction

   // work out one item's result and apply its effect on the layers
   function automatic outcome_type apply_item(input logic [2:0] kind, input logic [1:0] layer,
                                              input logic [15:0] px, input logic [15:0] py,
                                              input logic [15:0] amount,
                                              input logic [15:0] heading);
      outcome_type o;
      int          gx, gy, nx, ny, best, a;
      bit          on;
      logic [16:0] sum, ad;
      logic [15:0] s, d, keep;
      logic [31:0] w, best_w;
      o = '{level: '0, found: 1'b0, direction: '0, kind: kind};
      gx = int'(px[14:0] >> shift_reg);
      gy = int'(py[14:0] >> shift_reg);
      on = layer < NUM_LAYERS && !px[15] && !py[15] && gx < cols_used() && gy < rows_used();
      case (kind)
         KIND_DEPOSIT: if (on) begin
            a = cell_addr(layer, gx, gy);
            sum = cell_level[a] + amount;
            if (sum > ceiling_reg) sum = ceiling_reg;
            cell_level[a] = sum[15:0];
         end
         KIND_SAMPLE: if (on) o.level = cell_level[cell_addr(layer, gx, gy)];
         KIND_STEER: if (on) begin
            best = -1;
            best_w = '0;
            for (int i = 0; i < 8; i++) begin
               nx = gx + NBR_DX[i];
               ny = gy + NBR_DY[i];
               if (nx < 0 || ny < 0 || nx >= cols_used() || ny >= rows_used()) continue;
               s = cell_level[cell_addr(layer, nx, ny)];
               if (s < thresh_reg) continue;
               d = NBR_DIR[i] - heading;
               ad = d[15] ? 17'h10000 - d : {1'b0, d};
               // neighbors beyond a quarter turn count at 0.3
               w = (ad > 17'h04000) ? s * 32'd19661 : {s, 16'h0000};
               if (w > best_w) begin
                  best_w = w;
                  best = i;
               end
            end
            if (best >= 0) begin
               o.found = 1'b1;
               o.direction = NBR_DIR[best];
            end
         end
         KIND_EVAPORATE: for (int ly = 0; ly < NUM_LAYERS; ly++) begin
            keep = (ly == LAYER_DANGER) ? danger_reg : trail_reg;
            for (int i = 0; i < LAYER_CELLS; i++)
               cell_level[ly * LAYER_CELLS + i] = 16'((32'(cell_level[ly * LAYER_CELLS + i])
                                                       * keep) >> 16);
         end
         KIND_CLEAR: for (int i = 0; i < STORE_DEPTH; i++) cell_level[i] = '0;
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) cell_level[i] = '0;
         cols_reg = 8'd128;
         rows_reg = 8'd128;
         shift_reg = 4'd4;
         ceiling_reg = 16'hFFFF;
         thresh_reg = 16'd1;
         trail_reg = 16'hFFFF;
         danger_reg = 16'hFFFF;
         outcome_q.delete();
         fail_count = 0;
      end else begin
         // results leave only after their item is accepted, so check first
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("unexpected result item level=%0h kind=%0d", rsp_tdata[15:0], rsp_tuser);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tdata[15:0] !== want.level) begin
                  $error("level: expected %0h, got %0h", want.level, rsp_tdata[15:0]);
                  fail_count++;
               end
               if (rsp_tdata[16] !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_tdata[16]);
                  fail_count++;
               end
               if (rsp_tdata[32:17] !== want.direction) begin
                  $error("direction: expected %0h, got %0h", want.direction,
                         rsp_tdata[32:17]);
                  fail_count++;
               end
               if (rsp_tuser !== want.kind) begin
                  $error("done_kind: expected %0d, got %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(apply_item(req_tuser[2:0], req_tuser[4:3], req_tdata[15:0],
                                           req_tdata[31:16], req_tdata[47:32],
                                           req_tdata[63:48]));
         if (csr_we) begin
            case (csr_addr)
               CSR_GRID_COLS:   cols_reg = csr_wdata[7:0];
               CSR_GRID_ROWS:   rows_reg = csr_wdata[7:0];
               CSR_CELL_SHIFT:  shift_reg = csr_wdata[3:0];
               CSR_MAX_LEVEL:   ceiling_reg = csr_wdata;
               CSR_THRESHOLD:   thresh_reg = csr_wdata;
               CSR_TRAIL_KEEP:  trail_reg = csr_wdata;
               CSR_DANGER_KEEP: danger_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = outcome_q.size();
   end

endmodule

// ===== tb/tb_pheromone_grid_engine.sv =====
// Top of the pheromone grid engine testbench: clock, reset, item and register stimulus,
// watchdog and verdict. Depends on pge_pkg, pge_checker and the engine RTL.
module tb_pheromone_grid_engine;
   import pge_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] KIND_RESERVED = 3'd5;   // 5 to 7 carry no operation
   localparam logic [1:0] LAYER_FOOD    = 2'd0;
   localparam logic [1:0] LAYER_HOME    = 2'd1;
   localparam logic [1:0] LAYER_NONE    = 2'd3;
   localparam logic [2:0] CSR_UNUSED    = 3'd7;
   localparam int IDLE_LIMIT = 200000;             // longer than clearing and one full sweep

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // pos_x[15:0], pos_y[31:16], amount[47:32], heading[63:48]
   logic [4:0]  req_tuser = '0;   // kind[2:0], layer[4:3]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // level[15:0], found[16], direction[32:17], zero[39:33]
   logic [2:0]  rsp_tuser;        // done_kind[2:0]
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count, pending;
   int          idle_cycles = 0;
   bit          calm = 1'b0;      // no idling on either side while set
   int          cols_now = 128, rows_now = 128, shift_now = 4;
   int          sweeps_left = 8;  // evaporate and clear each walk the whole store

   pheromone_grid_engine dut (.*);

   pge_checker scoreboard (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // unless calm is set, the receiver stalls about 17 percent of the time
   always @(negedge clock) rsp_tready <= calm || ($urandom_range(99) >= 17);

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // offer one item and hold it until accepted
   task automatic send_item(input logic [2:0] kind, input logic [1:0] layer,
                            input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] amount, input logic [15:0] heading);
      while (!calm && $urandom_range(99) < 17) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {heading, amount, py, px};
      req_tuser = {layer, kind};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // registers change only once every result is back
   task automatic write_regs(input int cols, input int rows, input int shift,
                             input logic [15:0] ceiling, input logic [15:0] thresh,
                             input logic [15:0] trail, input logic [15:0] danger);
      logic [2:0]  idx [7];
      logic [15:0] val [7];
      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (8) @(negedge clock);
      idx = '{CSR_GRID_COLS, CSR_GRID_ROWS, CSR_CELL_SHIFT, CSR_MAX_LEVEL, CSR_THRESHOLD,
              CSR_TRAIL_KEEP, CSR_DANGER_KEEP};
      val = '{16'(cols), 16'(rows), 16'(shift), ceiling, thresh, trail, danger};
      for (int i = 0; i < 7; i++) begin
         csr_we = 1'b1;
         csr_addr = idx[i];
         csr_wdata = val[i];
         @(negedge clock);
      end
      csr_we = 1'b0;
      cols_now = (cols & 255) > MAX_COLS ? MAX_COLS : (cols & 255);
      rows_now = (rows & 255) > MAX_ROWS ? MAX_ROWS : (rows & 255);
      shift_now = shift & 15;
   endtask

   // mostly on or just past the grid, sometimes negative or anywhere
   function automatic logic [15:0] pick_coord(input int cells, input int shift);
      int          r;
      logic [31:0] v;
      r = $urandom_range(99);
      if (r < 85) begin
         v = ($urandom_range(cells) << shift) | ($urandom & ((32'd1 << shift) - 1));
         return v[15:0];
      end
      if (r < 92) return {1'b1, 15'($urandom)};
      return 16'($urandom);
   endfunction

   task automatic random_items(input int count);
      int          r;
      logic [2:0]  kind;
      logic [1:0]  layer;
      logic [15:0] amount, heading;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(999);
         if (r < 350) kind = KIND_DEPOSIT;
         else if (r < 600) kind = KIND_SAMPLE;
         else if (r < 950) kind = KIND_STEER;
         else if (r < 975) kind = KIND_RESERVED + 3'($urandom_range(2));
         else if (sweeps_left > 0) begin
            sweeps_left--;
            kind = (r < 988) ? KIND_EVAPORATE : KIND_CLEAR;
         end else kind = KIND_STEER;
         layer = ($urandom_range(99) < 95) ? 2'($urandom_range(2)) : LAYER_NONE;
         r = $urandom_range(99);
         amount = (r < 30) ? 16'($urandom_range(300)) : (r < 40) ? 16'hFFFF : 16'($urandom);
         // a quarter of headings sit on or next to the quarter-turn borders, the rest are random
         r = $urandom_range(99);
         heading = (r < 25) ? 16'($urandom_range(7) * 16'h2000 + $urandom_range(2) - 1)
                            : 16'($urandom);
         send_item(kind, layer, pick_coord(cols_now, shift_now), pick_coord(rows_now, shift_now),
                   amount, heading);
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed: saturation, steer ahead and behind, off-grid, bad layer, odd kinds, sweeps
      write_regs(128, 128, 4, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
      send_item(KIND_DEPOSIT, LAYER_FOOD, 16'd0, 16'd0, 16'hFFFF, 16'h0000);
      send_item(KIND_DEPOSIT, LAYER_FOOD, 16'd0, 16'd0, 16'd5, 16'hFFFF);
      send_item(KIND_SAMPLE, LAYER_FOOD, 16'd0, 16'd0, 16'd0, 16'd0);
      send_item(KIND_DEPOSIT, LAYER_HOME, 16'd16, 16'd16, 16'd1000, 16'd0);
      send_item(KIND_DEPOSIT, LAYER_HOME, 16'd32, 16'd16, 16'd3000, 16'd0);
      send_item(KIND_STEER, LAYER_HOME, 16'd16, 16'd32, 16'd0, 16'hC000);
      send_item(KIND_STEER, LAYER_HOME, 16'd16, 16'd32, 16'd0, 16'h4000);
      send_item(KIND_STEER, LAYER_HOME, 16'd0, 16'd0, 16'd0, 16'h0000);
      send_item(KIND_STEER, LAYER_FOOD, 16'd16, 16'd16, 16'd0, 16'h8000);
      send_item(KIND_SAMPLE, LAYER_FOOD, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0);
      send_item(KIND_SAMPLE, LAYER_FOOD, 16'h8000, 16'd0, 16'd0, 16'd0);
      send_item(KIND_DEPOSIT, LAYER_NONE, 16'd0, 16'd0, 16'd77, 16'd0);
      send_item(KIND_SAMPLE, LAYER_NONE, 16'd0, 16'd0, 16'd0, 16'd0);
      send_item(KIND_STEER, LAYER_NONE, 16'd16, 16'd16, 16'd0, 16'd0);
      send_item(KIND_RESERVED, LAYER_FOOD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(KIND_RESERVED + 3'd1, LAYER_HOME, 16'd0, 16'd0, 16'd9, 16'd0);
      send_item(KIND_RESERVED + 3'd2, LAYER_DANGER, 16'd16, 16'd0, 16'd0, 16'd0);
      send_item(KIND_DEPOSIT, LAYER_DANGER, 16'h07F0, 16'h07F0, 16'h8001, 16'd0);
      send_item(KIND_SAMPLE, LAYER_DANGER, 16'h07FF, 16'h07FF, 16'd0, 16'd0);
      send_item(KIND_EVAPORATE, LAYER_FOOD, 16'd0, 16'd0, 16'd0, 16'd0);
      send_item(KIND_SAMPLE, LAYER_FOOD, 16'd0, 16'd0, 16'd0, 16'd0);
      send_item(KIND_CLEAR, LAYER_FOOD, 16'd0, 16'd0, 16'd0, 16'd0);
      send_item(KIND_SAMPLE, LAYER_HOME, 16'd16, 16'd16, 16'd0, 16'd0);

      // random phases over small, tiny, full, empty and narrow grids
      write_regs(8, 6, 2, 16'hFFFF, 16'd1, 16'hC000, 16'h8000);
      random_items(150);
      calm = 1'b1;
      write_regs(1, 1, 0, 16'd300, 16'd0, 16'hFFFF, 16'h0000);
      random_items(150);
      calm = 1'b0;
      write_regs(128, 128, 8, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
      random_items(150);
      write_regs(255, 0, 15, 16'h0000, 16'd0, 16'h8000, 16'h8000);
      // a write past the last register must change nothing
      csr_we = 1'b1;
      csr_addr = CSR_UNUSED;
      csr_wdata = 16'hFFFF;
      @(negedge clock);
      csr_we = 1'b0;
      random_items(40);
      write_regs(5, 128, 3, 16'd40000, 16'd200, 16'h8000, 16'hE000);
      random_items(240);

      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// ===== pheromone_grid_engine.f =====
hw/rtl/pge_pkg.sv
hw/rtl/pge_ram.sv
hw/rtl/pge_datapath.sv
hw/rtl/pge_ctrl.sv
hw/rtl/pheromone_grid_engine.sv
tb/pge_checker.sv
tb/tb_pheromone_grid_engine.sv
